### hw/rtl/dclr_pkg.sv
// shared types, constants and helpers for the composition and longest-run block
package dclr_pkg;

  localparam int MAX_LENGTH  = 65536;
  localparam int CNT_W       = 17;
  localparam int SYM_W       = 8;
  localparam int SHARE_W     = 14;
  localparam int SHARE_SCALE = 10000;
  localparam int PROD_W      = CNT_W + SHARE_W;
  localparam int NUM_BASES   = 4;
  localparam int BASE_W      = $clog2(NUM_BASES);
  localparam int STEP_W      = $clog2(SHARE_W);

  localparam logic [SYM_W-1:0] SYM_A = 8'h41;
  localparam logic [SYM_W-1:0] SYM_C = 8'h43;
  localparam logic [SYM_W-1:0] SYM_G = 8'h47;
  localparam logic [SYM_W-1:0] SYM_T = 8'h54;

  localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_LENGTH);
  localparam logic [SHARE_W-1:0] SCALE_VAL = SHARE_W'(SHARE_SCALE);

  // summary of one finished sequence, handed from front to back
  typedef struct packed {
    logic [NUM_BASES-1:0][CNT_W-1:0] counts;
    logic [CNT_W-1:0]                total;
    logic [SYM_W-1:0]                run_symbol;
    logic [CNT_W-1:0]                run_length;
  } dclr_rec_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } dclr_bk_state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v < CNT_MAX) ? v + CNT_W'(1) : CNT_MAX;
    return r;
  endfunction

endpackage

### hw/rtl/dclr_front.sv
// front part: per-byte counting and run tracking, emits one summary per sequence
module dclr_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [dclr_pkg::SYM_W-1:0] symbol,
  input  logic                     last,
  output logic                     rec_push,
  output dclr_pkg::dclr_rec_t      rec
);

  logic [dclr_pkg::NUM_BASES-1:0][dclr_pkg::CNT_W-1:0] tally, tally_next;
  logic [dclr_pkg::CNT_W-1:0] length_so_far, length_so_far_next;
  logic [dclr_pkg::SYM_W-1:0] cur_sym, cur_sym_next;
  logic [dclr_pkg::CNT_W-1:0] cur_len, cur_len_next;
  logic [dclr_pkg::SYM_W-1:0] best_sym, best_sym_next;
  logic [dclr_pkg::CNT_W-1:0] best_len, best_len_next;
  logic [dclr_pkg::SYM_W-1:0] fin_sym;
  logic [dclr_pkg::CNT_W-1:0] fin_len;

  always_comb begin
    tally_next = tally;
    case (symbol)
      dclr_pkg::SYM_A: tally_next[0] = dclr_pkg::sat_inc(tally[0]);
      dclr_pkg::SYM_C: tally_next[1] = dclr_pkg::sat_inc(tally[1]);
      dclr_pkg::SYM_G: tally_next[2] = dclr_pkg::sat_inc(tally[2]);
      dclr_pkg::SYM_T: tally_next[3] = dclr_pkg::sat_inc(tally[3]);
      default: tally_next = tally;
    endcase
    length_so_far_next = dclr_pkg::sat_inc(length_so_far);

    best_sym_next = best_sym;
    best_len_next = best_len;
    if (cur_len == '0 || symbol == cur_sym) begin
      cur_sym_next = symbol;
      cur_len_next = dclr_pkg::sat_inc(cur_len);
    end else begin
      // run broken: keep it only if strictly longer, so ties favor the earlier run
      if (cur_len > best_len) begin
        best_sym_next = cur_sym;
        best_len_next = cur_len;
      end
      cur_sym_next = symbol;
      cur_len_next = dclr_pkg::CNT_W'(1);
    end

    if (cur_len_next > best_len_next) begin
      fin_sym = cur_sym_next;
      fin_len = cur_len_next;
    end else begin
      fin_sym = best_sym_next;
      fin_len = best_len_next;
    end
  end

  assign rec_push = accept && last;

  always_comb begin
    rec.counts     = tally_next;
    rec.total      = length_so_far_next;
    rec.run_symbol = fin_sym;
    rec.run_length = fin_len;
  end

  always_ff @(posedge clk) begin
    if (rst || rec_push) begin
      tally         <= '0;
      length_so_far <= '0;
      cur_sym       <= '0;
      cur_len       <= '0;
      best_sym      <= '0;
      best_len      <= '0;
    end else if (accept) begin
      tally         <= tally_next;
      length_so_far <= length_so_far_next;
      cur_sym       <= cur_sym_next;
      cur_len       <= cur_len_next;
      best_sym      <= best_sym_next;
      best_len      <= best_len_next;
    end
  end

endmodule

### hw/rtl/dclr_queue.sv
// two-entry queue of sequence summaries between front and back
module dclr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dclr_pkg::dclr_rec_t wr_data,
  input  logic                pop,
  output dclr_pkg::dclr_rec_t rd_data,
  output logic                q_full,
  output logic                q_empty
);

  dclr_pkg::dclr_rec_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign q_full  = (fill == 2'd2);
  assign q_empty = (fill == 2'd0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hw/rtl/dclr_back.sv
// back part: four shares by multiply and bit-serial restoring division, result register
module dclr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  dclr_pkg::dclr_rec_t       q_head,
  output logic                      q_pop,
  input  logic                      pop,
  output logic                      empty,
  output logic [dclr_pkg::CNT_W-1:0]   count_a,
  output logic [dclr_pkg::CNT_W-1:0]   count_c,
  output logic [dclr_pkg::CNT_W-1:0]   count_g,
  output logic [dclr_pkg::CNT_W-1:0]   count_t,
  output logic [dclr_pkg::CNT_W-1:0]   total_length,
  output logic [dclr_pkg::SHARE_W-1:0] share_a,
  output logic [dclr_pkg::SHARE_W-1:0] share_c,
  output logic [dclr_pkg::SHARE_W-1:0] share_g,
  output logic [dclr_pkg::SHARE_W-1:0] share_t,
  output logic [dclr_pkg::SYM_W-1:0]   run_symbol,
  output logic [dclr_pkg::CNT_W-1:0]   run_length
);

  dclr_pkg::dclr_bk_state_t state, state_next;
  dclr_pkg::dclr_rec_t      rec;
  logic [dclr_pkg::BASE_W-1:0]  sel;
  logic [dclr_pkg::STEP_W-1:0]  step;
  logic [dclr_pkg::CNT_W-1:0]   rem;
  logic [dclr_pkg::SHARE_W-1:0] low;
  logic [dclr_pkg::SHARE_W-1:0] quo;
  logic [dclr_pkg::NUM_BASES-1:0][dclr_pkg::SHARE_W-1:0] shares;
  logic out_valid;

  logic [dclr_pkg::PROD_W-1:0]  product;
  logic [dclr_pkg::CNT_W:0]     trial;
  logic                         qbit;
  logic [dclr_pkg::CNT_W-1:0]   rem_next;
  logic                         div_last;
  logic                         base_last;
  logic                         out_take;
  logic                         out_load;

  assign product = dclr_pkg::PROD_W'(rec.counts[sel]) * dclr_pkg::PROD_W'(dclr_pkg::SCALE_VAL);
  assign trial   = {rem, low[dclr_pkg::SHARE_W-1]};
  assign qbit    = (trial >= {1'b0, rec.total});
  assign rem_next = qbit ? dclr_pkg::CNT_W'(trial - {1'b0, rec.total})
                         : dclr_pkg::CNT_W'(trial);
  assign div_last  = (step == dclr_pkg::STEP_W'(dclr_pkg::SHARE_W - 1));
  assign base_last = (sel == dclr_pkg::BASE_W'(dclr_pkg::NUM_BASES - 1));
  assign out_take  = out_valid && pop;

  always_comb begin
    state_next = state;
    case (state)
      dclr_pkg::BK_IDLE: if (!q_empty) state_next = dclr_pkg::BK_MUL;
      dclr_pkg::BK_MUL:  state_next = dclr_pkg::BK_DIV;
      dclr_pkg::BK_DIV: begin
        if (div_last) begin
          state_next = base_last ? dclr_pkg::BK_DONE : dclr_pkg::BK_MUL;
        end
      end
      dclr_pkg::BK_DONE: if (!out_valid || out_take) state_next = dclr_pkg::BK_IDLE;
      default: state_next = dclr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state)
      dclr_pkg::BK_IDLE: q_pop    = !q_empty;
      dclr_pkg::BK_DONE: out_load = !out_valid || out_take;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dclr_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      dclr_pkg::BK_IDLE: begin
        rec <= q_head;
        sel <= '0;
      end
      dclr_pkg::BK_MUL: begin
        // quotient fits share width, so the upper product bits are below the divisor
        rem  <= product[dclr_pkg::PROD_W-1:dclr_pkg::SHARE_W];
        low  <= product[dclr_pkg::SHARE_W-1:0];
        step <= '0;
      end
      dclr_pkg::BK_DIV: begin
        rem  <= rem_next;
        low  <= {low[dclr_pkg::SHARE_W-2:0], 1'b0};
        quo  <= {quo[dclr_pkg::SHARE_W-2:0], qbit};
        step <= step + dclr_pkg::STEP_W'(1);
        if (div_last) begin
          shares[sel] <= {quo[dclr_pkg::SHARE_W-2:0], qbit};
          sel         <= sel + dclr_pkg::BASE_W'(1);
        end
      end
      default: begin
        rec <= rec;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      count_a      <= rec.counts[0];
      count_c      <= rec.counts[1];
      count_g      <= rec.counts[2];
      count_t      <= rec.counts[3];
      total_length <= rec.total;
      share_a      <= shares[0];
      share_c      <= shares[1];
      share_g      <= shares[2];
      share_t      <= shares[3];
      run_symbol   <= rec.run_symbol;
      run_length   <= rec.run_length;
    end
  end

  assign empty = !out_valid;

endmodule

### hw/rtl/dna_composition_longest_run.sv
// top level: base composition, shares and longest run of a byte sequence
// throughput: one byte per cycle into the counters; push stalls only when the
//   two-entry summary queue is full; the back part takes a new summary only when idle
// back part: loads a summary, then per base a multiply step and a bit-serial division
//   producing 14 quotient bits, then loads the result register
// reset: synchronous rst clears counters, queue, back state and the result valid flag
module dna_composition_longest_run (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [dclr_pkg::SYM_W-1:0]   symbol,
  input  logic                         last,
  output logic                         empty,
  input  logic                         pop,
  output logic [dclr_pkg::CNT_W-1:0]   count_a,
  output logic [dclr_pkg::CNT_W-1:0]   count_c,
  output logic [dclr_pkg::CNT_W-1:0]   count_g,
  output logic [dclr_pkg::CNT_W-1:0]   count_t,
  output logic [dclr_pkg::CNT_W-1:0]   total_length,
  output logic [dclr_pkg::SHARE_W-1:0] share_a,
  output logic [dclr_pkg::SHARE_W-1:0] share_c,
  output logic [dclr_pkg::SHARE_W-1:0] share_g,
  output logic [dclr_pkg::SHARE_W-1:0] share_t,
  output logic [dclr_pkg::SYM_W-1:0]   run_symbol,
  output logic [dclr_pkg::CNT_W-1:0]   run_length
);

  logic                accept;
  logic                rec_push;
  dclr_pkg::dclr_rec_t rec;
  dclr_pkg::dclr_rec_t q_head;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;

  // an input transfer happens when push is high and the queue has room for a summary
  assign full   = q_full;
  assign accept = push && !q_full;

  dclr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .symbol   (symbol),
    .last     (last),
    .rec_push (rec_push),
    .rec      (rec)
  );

  dclr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (rec_push),
    .wr_data (rec),
    .pop     (q_pop),
    .rd_data (q_head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  dclr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .count_a      (count_a),
    .count_c      (count_c),
    .count_g      (count_g),
    .count_t      (count_t),
    .total_length (total_length),
    .share_a      (share_a),
    .share_c      (share_c),
    .share_g      (share_g),
    .share_t      (share_t),
    .run_symbol   (run_symbol),
    .run_length   (run_length)
  );

endmodule
